### rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Character codes, the escape state encoding, the request that passes from
// the classifying front end to the output back end, and hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Default depth of the request queue between front and back ends.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Characters with a special meaning in an encoded string.
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SPACE   = 8'h20;

  // Escape tracking: nothing pending, '%' held, '%' and first digit held.
  typedef enum logic [2:0] {
    ESC_IDLE  = 3'b001,
    ESC_PCT   = 3'b010,
    ESC_DIGIT = 3'b100
  } esc_state_t;

  // One request: up to three output bytes caused by one input byte.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } upd_req_t;

  // True for 0-9, A-F and a-f.
  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Value of a hex digit; only meaningful when is_hex holds.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    if (b[6]) begin
      v = 4'(b[3:0] + 4'd9);
    end else begin
      v = b[3:0];
    end
    return v;
  endfunction

endpackage

### rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: input classifier
// Accepts raw bytes, tracks the escape state and turns each byte into a
// request of zero to three output bytes for the queue.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_plus_means_space,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output upd_pkg::upd_req_t q_req
);
  import upd_pkg::*;

  esc_state_t state_r, state_nxt;
  logic [7:0] held_r;
  logic       plus_r;

  logic       accept;
  logic       b_hex;
  logic       f_emit;
  logic [7:0] f_byte;
  logic       f_pct;
  logic [1:0] cnt;
  logic [2:0][7:0] bytes;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b_hex    = is_hex(in_byte);

  // Treatment of the current byte when looked at with no escape pending.
  always_comb begin
    f_emit = 1'b1;
    f_byte = in_byte;
    f_pct  = 1'b0;
    if (in_byte == CHR_PERCENT) begin
      f_emit = in_last;
      f_pct  = !in_last;
    end else if (in_byte == CHR_PLUS && plus_r) begin
      f_byte = CHR_SPACE;
    end
  end

  // Output bytes and next escape state for the current byte.
  always_comb begin
    cnt       = 2'd0;
    bytes     = '0;
    state_nxt = state_r;
    case (state_r)
      ESC_PCT: begin
        if (b_hex) begin
          if (in_last) begin
            cnt       = 2'd2;
            bytes[0]  = CHR_PERCENT;
            bytes[1]  = in_byte;
            state_nxt = ESC_IDLE;
          end else begin
            state_nxt = ESC_DIGIT;
          end
        end else begin
          cnt       = 2'(2'd1 + {1'b0, f_emit});
          bytes[0]  = CHR_PERCENT;
          bytes[1]  = f_byte;
          state_nxt = f_pct ? ESC_PCT : ESC_IDLE;
        end
      end
      ESC_DIGIT: begin
        if (b_hex) begin
          cnt       = 2'd1;
          bytes[0]  = {hex_val(held_r), hex_val(in_byte)};
          state_nxt = ESC_IDLE;
        end else begin
          cnt       = 2'(2'd2 + {1'b0, f_emit});
          bytes[0]  = CHR_PERCENT;
          bytes[1]  = held_r;
          bytes[2]  = f_byte;
          state_nxt = f_pct ? ESC_PCT : ESC_IDLE;
        end
      end
      default: begin
        cnt       = {1'b0, f_emit};
        bytes[0]  = f_byte;
        state_nxt = f_pct ? ESC_PCT : ESC_IDLE;
      end
    endcase
    if (in_last) begin
      state_nxt = ESC_IDLE;
    end
  end

  assign q_push      = accept && (cnt != 2'd0);
  assign q_req.cnt   = cnt;
  assign q_req.bytes = bytes;
  assign q_req.last  = in_last;

  // Escape state and plus mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ESC_IDLE;
      plus_r  <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        plus_r <= cfg_plus_means_space;
      end
    end
  end

  // First hex digit of a pending escape.
  always_ff @(posedge clk) begin
    if (accept && state_r == ESC_PCT) begin
      held_r <= in_byte;
    end
  end

  // A string end always leaves no escape pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> state_r == ESC_IDLE)
    else $error("escape still pending after string end");

  // A held digit never produces a request without a following byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r == ESC_PCT && b_hex && !in_last |-> !q_push)
    else $error("request pushed while first digit is held");

  // Every accepted last byte emits at least one output byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |-> q_push)
    else $error("string end produced no output");

endmodule

### rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue: request queue
// A short first-in first-out queue that decouples the classifier from the
// output serialiser.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_req_t push_req,
  input  logic              pop,
  output upd_pkg::upd_req_t head_req,
  output logic              full,
  output logic              not_empty
);
  import upd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  upd_req_t          slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_req  = slot_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  // Request storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: output serialiser
// Walks the head request's bytes, one per cycle unless out_ready stalls,
// into a registered output stage with run and string end flags.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  upd_pkg::upd_req_t head_req,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_end,
  output logic              out_string_end
);
  import upd_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       run_end_r, string_end_r;

  logic load;
  logic take;
  logic final_byte;

  // The output register can take a new byte when empty or being drained.
  assign load       = !valid_r || out_ready;
  assign take       = load && head_valid;
  assign final_byte = (idx_r == 2'(head_req.cnt - 2'd1));
  assign pop        = take && final_byte;

  // Byte index within the head request and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        idx_r <= final_byte ? 2'd0 : 2'(idx_r + 2'd1);
      end
      if (load) begin
        valid_r <= head_valid;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r       <= head_req.bytes[idx_r];
      run_end_r    <= final_byte;
      string_end_r <= final_byte && head_req.last;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_run_end    = run_end_r;
  assign out_string_end = string_end_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && string_end_r |-> run_end_r)
    else $error("string end without run end");

  assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < head_req.cnt)
    else $error("byte index beyond request length");

  assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == 2'd0)
    else $error("byte index left over with empty queue");

endmodule

### rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes %XX escapes, optionally maps '+' to space, flushes broken escapes.
// ----------------------------------------------------------------------------
// The decoder accepts one encoded byte per cycle and produces one decoded
// byte per cycle, each while not stalled. Most input bytes yield one output
// byte; a '%' or first hex digit of an escape yields none until the escape
// resolves, and a broken escape yields one to three bytes, which the output
// then emits one at a time. The request queue (QUEUE_DEPTH entries) absorbs
// this, so input only stalls once the queue has filled behind a multi-byte
// request or a stalled consumer. An accepted byte's first result passes
// through the queue and then the output register. Write plus mode only
// while no string is in flight.
module url_percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_plus_means_space,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_string_end
);
  import upd_pkg::*;

  upd_req_t push_req, head_req;
  logic     push, pop, q_full, q_not_empty;

  // Classifier and escape tracking.
  upd_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_plus_means_space (cfg_plus_means_space),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte              (in_byte),
    .in_last              (in_last),
    .q_full               (q_full),
    .q_push               (push),
    .q_req                (push_req)
  );

  // Request queue.
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .head_req  (head_req),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Output serialiser.
  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_req       (head_req),
    .head_valid     (q_not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule
